// ===== src/ssd_pkg.sv =====
// shared widths, latencies, item types and helpers for the segment distance pipeline
`default_nettype none

package ssd_pkg;

  localparam int CW       = 32;           // input coordinate width, Q16.16
  localparam int VW       = CW + 1;       // u, v, w components
  localparam int MW       = 68;           // multiplier operand width
  localparam int HW       = MW / 2;       // multiplier limb width
  localparam int PW       = 2 * MW;       // full product width
  localparam int DW       = PW - 2;       // divider remainder and divisor width
  localparam int QW       = CW + 1;       // rounded parameter, Q1.32
  localparam int QBITS    = QW + 1;       // quotient bits before rounding
  localparam int DIST_W   = 34;           // result width, Q18.16
  localparam int RW       = MW + 2;       // square root remainder width
  localparam int SQ_STEPS = PW / 2;       // one root bit per step
  localparam int RND_SH   = 32;           // 2^-48 units down to 2^-16 units
  localparam int NAX      = 3;
  localparam int NDOT     = 5;
  localparam int NPROD    = 6;

  localparam int MUL_LAT  = 5;
  localparam int DIV_LAT  = QBITS + 1;
  localparam int SQ_LAT   = SQ_STEPS + 1;
  localparam int DOT_DLY  = MUL_LAT + 1;
  localparam int GEO_DLY  = 2 * MUL_LAT + 4 + DIV_LAT;
  localparam int LAT      = 4 * MUL_LAT + DIV_LAT + SQ_LAT + 8;

  localparam logic [DIST_W-1:0] OUT_MAX = '1;

  // dot product slots
  localparam int DOT_A = 0;
  localparam int DOT_B = 1;
  localparam int DOT_C = 2;
  localparam int DOT_D = 3;
  localparam int DOT_E = 4;

  // second level product slots
  localparam int PR_AC = 0;
  localparam int PR_BB = 1;
  localparam int PR_BE = 2;
  localparam int PR_CD = 3;
  localparam int PR_AE = 4;
  localparam int PR_BD = 5;

  typedef logic signed [MW-1:0] mop_t;
  typedef logic signed [PW-1:0] prod_t;

  typedef struct packed {
    logic signed [CW-1:0] seg1_start_x;
    logic signed [CW-1:0] seg1_start_y;
    logic signed [CW-1:0] seg1_start_z;
    logic signed [CW-1:0] seg1_end_x;
    logic signed [CW-1:0] seg1_end_y;
    logic signed [CW-1:0] seg1_end_z;
    logic signed [CW-1:0] seg2_start_x;
    logic signed [CW-1:0] seg2_start_y;
    logic signed [CW-1:0] seg2_start_z;
    logic signed [CW-1:0] seg2_end_x;
    logic signed [CW-1:0] seg2_end_y;
    logic signed [CW-1:0] seg2_end_z;
  } seg_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] closest_distance;
  } dist_item_t;

  typedef struct packed {
    logic [NAX-1:0][VW-1:0] u;
    logic [NAX-1:0][VW-1:0] v;
    logic [NAX-1:0][VW-1:0] w;
  } geo_t;

  function automatic logic [VW-1:0] vdiff(input logic [CW-1:0] p, input logic [CW-1:0] q);
    return {p[CW-1], p} - {q[CW-1], q};
  endfunction

  function automatic mop_t v2m(input logic [VW-1:0] x);
    return {{(MW-VW){x[VW-1]}}, x};
  endfunction

  function automatic prod_t m2p(input logic [MW-1:0] x);
    return {{(PW-MW){x[MW-1]}}, x};
  endfunction

endpackage

`default_nettype wire

// ===== src/ssd_if.sv =====
// valid/ready channels for segment pairs and distance results
`default_nettype none

interface ssd_in_if;
  logic                  valid;
  logic                  ready;
  ssd_pkg::seg_item_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssd_out_if;
  logic                  valid;
  logic                  ready;
  ssd_pkg::dist_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/segment_segment_distance_3d.sv =====
// top level: closest distance between two 3d segments, fully pipelined
// Takes one segment pair per cycle while the output is not stalled and returns one Q18.16
// distance per pair, in order. The latency is set by the chain of 68x68 multipliers
// (five stages each, four in series), the two 34-step parameter dividers and the 68-step
// square root. The whole pipeline advances together: in_seg.ready is high whenever the
// output register is empty or is being taken in the same cycle, so a stalled result holds
// every stage and nothing is lost or repeated.
`default_nettype none

module segment_segment_distance_3d (
  input  logic      clk,
  input  logic      rst_n,
  ssd_in_if.sink    in_seg,
  ssd_out_if.source out_dist
);

  logic                            en;
  logic [ssd_pkg::LAT-1:0]         vld_r;

  logic [ssd_pkg::CW-1:0]          p0 [ssd_pkg::NAX];
  logic [ssd_pkg::CW-1:0]          p1 [ssd_pkg::NAX];
  logic [ssd_pkg::CW-1:0]          q0 [ssd_pkg::NAX];
  logic [ssd_pkg::CW-1:0]          q1 [ssd_pkg::NAX];
  ssd_pkg::geo_t                   geo_nxt, geo_r, geo_fin;
  ssd_pkg::geo_t                   geo_dly_r [ssd_pkg::GEO_DLY];
  logic [ssd_pkg::NAX-1:0][ssd_pkg::VW-1:0] w_dly_r [ssd_pkg::MUL_LAT];

  ssd_pkg::mop_t                   dop_a [ssd_pkg::NDOT][ssd_pkg::NAX];
  ssd_pkg::mop_t                   dop_b [ssd_pkg::NDOT][ssd_pkg::NAX];
  ssd_pkg::prod_t                  dprod [ssd_pkg::NDOT][ssd_pkg::NAX];
  ssd_pkg::mop_t                   dot_r [ssd_pkg::NDOT];
  ssd_pkg::mop_t                   dot_dly_r [ssd_pkg::DOT_DLY][ssd_pkg::NDOT];

  ssd_pkg::mop_t                   pop_a [ssd_pkg::NPROD];
  ssd_pkg::mop_t                   pop_b [ssd_pkg::NPROD];
  ssd_pkg::prod_t                  pprod [ssd_pkg::NPROD];
  ssd_pkg::prod_t                  det_r, sn0_r, tn0_r;

  ssd_pkg::prod_t                  ea, eb, ec, ed, ee;
  ssd_pkg::prod_t                  sn1_nxt, sd1_nxt, tn1_nxt, td1_nxt, nd_nxt;
  ssd_pkg::prod_t                  sn1_r, sd1_r, tn1_r, td1_r, nd_r, ndb_r, a1_r;
  ssd_pkg::prod_t                  sn2_nxt, sd2_nxt, tn2_nxt, cand;
  ssd_pkg::prod_t                  sn2_r, sd2_r, tn2_r, td2_r;
  logic                            reclamp;

  logic [ssd_pkg::QW-1:0]          sc, tc;
  ssd_pkg::mop_t                   cu_a [ssd_pkg::NAX];
  ssd_pkg::mop_t                   cv_a [ssd_pkg::NAX];
  ssd_pkg::mop_t                   sc_m, tc_m;
  ssd_pkg::prod_t                  cu_p [ssd_pkg::NAX];
  ssd_pkg::prod_t                  cv_p [ssd_pkg::NAX];
  ssd_pkg::mop_t                   res_r [ssd_pkg::NAX];
  ssd_pkg::prod_t                  sq [ssd_pkg::NAX];
  logic [ssd_pkg::PW-1:0]          s01_r, sq2_r, sum_r;
  logic [ssd_pkg::DIST_W-1:0]      distance;

  assign en           = !vld_r[ssd_pkg::LAT-1] || out_dist.ready;
  assign in_seg.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ssd_pkg::LAT-2:0], in_seg.valid};
    end
  end

  // stage 1: direction and offset vectors
  always_comb begin
    p0[0] = in_seg.data.seg1_start_x;  p0[1] = in_seg.data.seg1_start_y;
    p0[2] = in_seg.data.seg1_start_z;
    p1[0] = in_seg.data.seg1_end_x;    p1[1] = in_seg.data.seg1_end_y;
    p1[2] = in_seg.data.seg1_end_z;
    q0[0] = in_seg.data.seg2_start_x;  q0[1] = in_seg.data.seg2_start_y;
    q0[2] = in_seg.data.seg2_start_z;
    q1[0] = in_seg.data.seg2_end_x;    q1[1] = in_seg.data.seg2_end_y;
    q1[2] = in_seg.data.seg2_end_z;
    for (int k = 0; k < ssd_pkg::NAX; k++) begin
      geo_nxt.u[k] = ssd_pkg::vdiff(p1[k], p0[k]);
      geo_nxt.v[k] = ssd_pkg::vdiff(q1[k], q0[k]);
      geo_nxt.w[k] = ssd_pkg::vdiff(p0[k], q0[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo_r        <= geo_nxt;
      geo_dly_r[0] <= geo_r;
      for (int i = 1; i < ssd_pkg::GEO_DLY; i++) begin
        geo_dly_r[i] <= geo_dly_r[i-1];
      end
      w_dly_r[0] <= geo_fin.w;
      for (int i = 1; i < ssd_pkg::MUL_LAT; i++) begin
        w_dly_r[i] <= w_dly_r[i-1];
      end
    end
  end

  assign geo_fin = geo_dly_r[ssd_pkg::GEO_DLY-1];

  // dot products a..e
  always_comb begin
    for (int k = 0; k < ssd_pkg::NAX; k++) begin
      dop_a[ssd_pkg::DOT_A][k] = ssd_pkg::v2m(geo_r.u[k]);
      dop_b[ssd_pkg::DOT_A][k] = ssd_pkg::v2m(geo_r.u[k]);
      dop_a[ssd_pkg::DOT_B][k] = ssd_pkg::v2m(geo_r.u[k]);
      dop_b[ssd_pkg::DOT_B][k] = ssd_pkg::v2m(geo_r.v[k]);
      dop_a[ssd_pkg::DOT_C][k] = ssd_pkg::v2m(geo_r.v[k]);
      dop_b[ssd_pkg::DOT_C][k] = ssd_pkg::v2m(geo_r.v[k]);
      dop_a[ssd_pkg::DOT_D][k] = ssd_pkg::v2m(geo_r.u[k]);
      dop_b[ssd_pkg::DOT_D][k] = ssd_pkg::v2m(geo_r.w[k]);
      dop_a[ssd_pkg::DOT_E][k] = ssd_pkg::v2m(geo_r.v[k]);
      dop_b[ssd_pkg::DOT_E][k] = ssd_pkg::v2m(geo_r.w[k]);
    end
  end

  for (genvar i = 0; i < ssd_pkg::NDOT; i++) begin : g_dot
    for (genvar k = 0; k < ssd_pkg::NAX; k++) begin : g_ax
      ssd_mul u_mul (
        .clk  (clk),
        .en   (en),
        .op_a (dop_a[i][k]),
        .op_b (dop_b[i][k]),
        .prod (dprod[i][k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < ssd_pkg::NDOT; i++) begin
        dot_r[i] <= dprod[i][0][ssd_pkg::MW-1:0] + dprod[i][1][ssd_pkg::MW-1:0]
                  + dprod[i][2][ssd_pkg::MW-1:0];
        dot_dly_r[0][i] <= dot_r[i];
        for (int j = 1; j < ssd_pkg::DOT_DLY; j++) begin
          dot_dly_r[j][i] <= dot_dly_r[j-1][i];
        end
      end
    end
  end

  // determinant and unclamped numerators
  always_comb begin
    pop_a[ssd_pkg::PR_AC] = dot_r[ssd_pkg::DOT_A]; pop_b[ssd_pkg::PR_AC] = dot_r[ssd_pkg::DOT_C];
    pop_a[ssd_pkg::PR_BB] = dot_r[ssd_pkg::DOT_B]; pop_b[ssd_pkg::PR_BB] = dot_r[ssd_pkg::DOT_B];
    pop_a[ssd_pkg::PR_BE] = dot_r[ssd_pkg::DOT_B]; pop_b[ssd_pkg::PR_BE] = dot_r[ssd_pkg::DOT_E];
    pop_a[ssd_pkg::PR_CD] = dot_r[ssd_pkg::DOT_C]; pop_b[ssd_pkg::PR_CD] = dot_r[ssd_pkg::DOT_D];
    pop_a[ssd_pkg::PR_AE] = dot_r[ssd_pkg::DOT_A]; pop_b[ssd_pkg::PR_AE] = dot_r[ssd_pkg::DOT_E];
    pop_a[ssd_pkg::PR_BD] = dot_r[ssd_pkg::DOT_B]; pop_b[ssd_pkg::PR_BD] = dot_r[ssd_pkg::DOT_D];
  end

  for (genvar i = 0; i < ssd_pkg::NPROD; i++) begin : g_prod
    ssd_mul u_mul (
      .clk  (clk),
      .en   (en),
      .op_a (pop_a[i]),
      .op_b (pop_b[i]),
      .prod (pprod[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= pprod[ssd_pkg::PR_AC] - pprod[ssd_pkg::PR_BB];
      sn0_r <= pprod[ssd_pkg::PR_BE] - pprod[ssd_pkg::PR_CD];
      tn0_r <= pprod[ssd_pkg::PR_AE] - pprod[ssd_pkg::PR_BD];
    end
  end

  // first clamp: parallel case and s against segment one
  always_comb begin
    ea = ssd_pkg::m2p(dot_dly_r[ssd_pkg::DOT_DLY-1][ssd_pkg::DOT_A]);
    eb = ssd_pkg::m2p(dot_dly_r[ssd_pkg::DOT_DLY-1][ssd_pkg::DOT_B]);
    ec = ssd_pkg::m2p(dot_dly_r[ssd_pkg::DOT_DLY-1][ssd_pkg::DOT_C]);
    ed = ssd_pkg::m2p(dot_dly_r[ssd_pkg::DOT_DLY-1][ssd_pkg::DOT_D]);
    ee = ssd_pkg::m2p(dot_dly_r[ssd_pkg::DOT_DLY-1][ssd_pkg::DOT_E]);
    nd_nxt = -ed;
    if (det_r[ssd_pkg::PW-1] || det_r == '0) begin
      sn1_nxt = '0;
      sd1_nxt = ssd_pkg::PW'(1);
      tn1_nxt = ee;
      td1_nxt = ec;
    end else if (sn0_r[ssd_pkg::PW-1]) begin
      sn1_nxt = '0;
      sd1_nxt = det_r;
      tn1_nxt = ee;
      td1_nxt = ec;
    end else if (sn0_r > det_r) begin
      sn1_nxt = det_r;
      sd1_nxt = det_r;
      tn1_nxt = ee + eb;
      td1_nxt = ec;
    end else begin
      sn1_nxt = sn0_r;
      sd1_nxt = det_r;
      tn1_nxt = tn0_r;
      td1_nxt = det_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn1_r <= sn1_nxt;
      sd1_r <= sd1_nxt;
      tn1_r <= tn1_nxt;
      td1_r <= td1_nxt;
      nd_r  <= nd_nxt;
      ndb_r <= nd_nxt + eb;
      a1_r  <= ea;
    end
  end

  // second clamp: t against segment two, then s again
  always_comb begin
    sn2_nxt = sn1_r;
    sd2_nxt = sd1_r;
    tn2_nxt = tn1_r;
    cand    = nd_r;
    reclamp = 1'b0;
    if (tn1_r[ssd_pkg::PW-1]) begin
      tn2_nxt = '0;
      cand    = nd_r;
      reclamp = 1'b1;
    end else if (tn1_r > td1_r) begin
      tn2_nxt = td1_r;
      cand    = ndb_r;
      reclamp = 1'b1;
    end
    if (reclamp) begin
      if (cand[ssd_pkg::PW-1]) begin
        sn2_nxt = '0;
      end else if (cand > a1_r) begin
        sn2_nxt = sd1_r;
      end else begin
        sn2_nxt = cand;
        sd2_nxt = a1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn2_r <= sn2_nxt;
      sd2_r <= sd2_nxt;
      tn2_r <= tn2_nxt;
      td2_r <= td1_r;
    end
  end

  ssd_div u_div_s (
    .clk (clk),
    .en  (en),
    .num (sn2_r),
    .den (sd2_r),
    .quo (sc)
  );

  ssd_div u_div_t (
    .clk (clk),
    .en  (en),
    .num (tn2_r),
    .den (td2_r),
    .quo (tc)
  );

  // closest point difference w + sc*u - tc*v
  always_comb begin
    sc_m = {{(ssd_pkg::MW-ssd_pkg::QW){1'b0}}, sc};
    tc_m = {{(ssd_pkg::MW-ssd_pkg::QW){1'b0}}, tc};
    for (int k = 0; k < ssd_pkg::NAX; k++) begin
      cu_a[k] = ssd_pkg::v2m(geo_fin.u[k]);
      cv_a[k] = ssd_pkg::v2m(geo_fin.v[k]);
    end
  end

  for (genvar k = 0; k < ssd_pkg::NAX; k++) begin : g_comp
    ssd_mul u_mul_u (
      .clk  (clk),
      .en   (en),
      .op_a (cu_a[k]),
      .op_b (sc_m),
      .prod (cu_p[k])
    );
    ssd_mul u_mul_v (
      .clk  (clk),
      .en   (en),
      .op_a (cv_a[k]),
      .op_b (tc_m),
      .prod (cv_p[k])
    );
    ssd_mul u_mul_sq (
      .clk  (clk),
      .en   (en),
      .op_a (res_r[k]),
      .op_b (res_r[k]),
      .prod (sq[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ssd_pkg::NAX; k++) begin
        res_r[k] <= (ssd_pkg::v2m(w_dly_r[ssd_pkg::MUL_LAT-1][k]) <<< ssd_pkg::CW)
                  + cu_p[k][ssd_pkg::MW-1:0] - cv_p[k][ssd_pkg::MW-1:0];
      end
      s01_r <= sq[0] + sq[1];
      sq2_r <= sq[2];
      sum_r <= s01_r + sq2_r;
    end
  end

  ssd_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .rad      (sum_r),
    .distance (distance)
  );

  assign out_dist.valid                 = vld_r[ssd_pkg::LAT-1];
  assign out_dist.data.closest_distance = distance;

endmodule

`default_nettype wire

// ===== src/ssd_mul.sv =====
// five stage signed 68x68 multiplier built from four 34x34 partial products
`default_nettype none

module ssd_mul (
  input  logic           clk,
  input  logic           en,
  input  ssd_pkg::mop_t  op_a,
  input  ssd_pkg::mop_t  op_b,
  output ssd_pkg::prod_t prod
);

  logic                          neg1_r, neg2_r, neg3_r, neg4_r;
  logic [ssd_pkg::MW-1:0]        am_r, bm_r;
  logic [2*ssd_pkg::HW-1:0]      pp00_r, pp01_r, pp10_r, pp11_r;
  logic [2*ssd_pkg::HW:0]        mid_r;
  logic [ssd_pkg::PW-1:0]        base_r, sum_r;
  ssd_pkg::prod_t                prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes
      neg1_r <= op_a[ssd_pkg::MW-1] ^ op_b[ssd_pkg::MW-1];
      am_r   <= op_a[ssd_pkg::MW-1] ? -op_a : op_a;
      bm_r   <= op_b[ssd_pkg::MW-1] ? -op_b : op_b;
      // partial products
      neg2_r <= neg1_r;
      pp00_r <= am_r[ssd_pkg::HW-1:0] * bm_r[ssd_pkg::HW-1:0];
      pp01_r <= am_r[ssd_pkg::HW-1:0] * bm_r[ssd_pkg::MW-1:ssd_pkg::HW];
      pp10_r <= am_r[ssd_pkg::MW-1:ssd_pkg::HW] * bm_r[ssd_pkg::HW-1:0];
      pp11_r <= am_r[ssd_pkg::MW-1:ssd_pkg::HW] * bm_r[ssd_pkg::MW-1:ssd_pkg::HW];
      // cross terms
      neg3_r <= neg2_r;
      mid_r  <= (2*ssd_pkg::HW+1)'(pp01_r) + (2*ssd_pkg::HW+1)'(pp10_r);
      base_r <= {pp11_r, pp00_r};
      neg4_r <= neg3_r;
      sum_r  <= base_r + (ssd_pkg::PW'(mid_r) << ssd_pkg::HW);
      prod_r <= neg4_r ? -$signed(sum_r) : $signed(sum_r);
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ===== src/ssd_div.sv =====
// pipelined restoring divider, num/den rounded half up to Q1.32, zero for non-positive operands
`default_nettype none

module ssd_div (
  input  logic                    clk,
  input  logic                    en,
  input  ssd_pkg::prod_t          num,
  input  ssd_pkg::prod_t          den,
  output logic [ssd_pkg::QW-1:0]  quo
);

  logic [ssd_pkg::DW-1:0]    rem_r   [ssd_pkg::QBITS];
  logic [ssd_pkg::DW-1:0]    den_r   [ssd_pkg::QBITS];
  logic [ssd_pkg::QBITS-1:0] q_r     [ssd_pkg::QBITS];
  logic                      zero_r  [ssd_pkg::QBITS];
  logic [ssd_pkg::DW-1:0]    rem_nxt [ssd_pkg::QBITS];
  logic [ssd_pkg::QBITS-1:0] q_nxt   [ssd_pkg::QBITS];
  logic [ssd_pkg::DW:0]      twice   [1:ssd_pkg::QBITS-1];
  logic [ssd_pkg::DW-1:0]    nu, de;
  logic                      zero_in;
  logic [ssd_pkg::QBITS:0]   rnd;
  logic [ssd_pkg::QW-1:0]    quo_r;

  always_comb begin
    zero_in = num[ssd_pkg::PW-1] || (num == '0) || den[ssd_pkg::PW-1] || (den == '0);
    nu = num[ssd_pkg::DW-1:0];
    de = den[ssd_pkg::DW-1:0];
    // numerator never exceeds the divisor, so the top bit is a single compare
    if (nu >= de) begin
      rem_nxt[0] = nu - de;
      q_nxt[0]   = ssd_pkg::QBITS'(1);
    end else begin
      rem_nxt[0] = nu;
      q_nxt[0]   = '0;
    end
    for (int k = 1; k < ssd_pkg::QBITS; k++) begin
      twice[k] = {rem_r[k-1], 1'b0};
      if (twice[k] >= {1'b0, den_r[k-1]}) begin
        rem_nxt[k] = ssd_pkg::DW'(twice[k] - {1'b0, den_r[k-1]});
        q_nxt[k]   = {q_r[k-1][ssd_pkg::QBITS-2:0], 1'b1};
      end else begin
        rem_nxt[k] = twice[k][ssd_pkg::DW-1:0];
        q_nxt[k]   = {q_r[k-1][ssd_pkg::QBITS-2:0], 1'b0};
      end
    end
    rnd = {1'b0, q_r[ssd_pkg::QBITS-1]} + (ssd_pkg::QBITS+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]  <= de;
      zero_r[0] <= zero_in;
      for (int k = 0; k < ssd_pkg::QBITS; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
      for (int k = 1; k < ssd_pkg::QBITS; k++) begin
        den_r[k]  <= den_r[k-1];
        zero_r[k] <= zero_r[k-1];
      end
      quo_r <= zero_r[ssd_pkg::QBITS-1] ? '0 : rnd[ssd_pkg::QW:1];
    end
  end

  assign quo = quo_r;

endmodule

`default_nettype wire

// ===== src/ssd_sqrt.sv =====
// pipelined integer square root, one root bit per stage, then round and saturate
`default_nettype none

module ssd_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ssd_pkg::PW-1:0]      rad,
  output logic [ssd_pkg::DIST_W-1:0]  distance
);

  logic [ssd_pkg::RW-1:0]   rem_r    [ssd_pkg::SQ_STEPS];
  logic [ssd_pkg::MW-1:0]   root_r   [ssd_pkg::SQ_STEPS];
  logic [ssd_pkg::PW-1:0]   rad_r    [ssd_pkg::SQ_STEPS];
  logic [ssd_pkg::RW-1:0]   in_rem   [ssd_pkg::SQ_STEPS];
  logic [ssd_pkg::MW-1:0]   in_root  [ssd_pkg::SQ_STEPS];
  logic [ssd_pkg::PW-1:0]   in_rad   [ssd_pkg::SQ_STEPS];
  logic [ssd_pkg::RW+1:0]   cur      [ssd_pkg::SQ_STEPS];
  logic [ssd_pkg::RW+1:0]   trial    [ssd_pkg::SQ_STEPS];
  logic [ssd_pkg::RW-1:0]   rem_nxt  [ssd_pkg::SQ_STEPS];
  logic [ssd_pkg::MW-1:0]   root_nxt [ssd_pkg::SQ_STEPS];
  logic [ssd_pkg::MW:0]     rnd;
  logic [ssd_pkg::DIST_W-1:0] dist_r;

  always_comb begin
    in_rem[0]  = '0;
    in_root[0] = '0;
    in_rad[0]  = rad;
    for (int k = 1; k < ssd_pkg::SQ_STEPS; k++) begin
      in_rem[k]  = rem_r[k-1];
      in_root[k] = root_r[k-1];
      in_rad[k]  = rad_r[k-1];
    end
    for (int k = 0; k < ssd_pkg::SQ_STEPS; k++) begin
      // bring down the next two radicand bits, try root*4+1
      cur[k]   = {in_rem[k], in_rad[k][ssd_pkg::PW-1:ssd_pkg::PW-2]};
      trial[k] = {2'b00, in_root[k], 2'b01};
      if (cur[k] >= trial[k]) begin
        rem_nxt[k]  = ssd_pkg::RW'(cur[k] - trial[k]);
        root_nxt[k] = {in_root[k][ssd_pkg::MW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = cur[k][ssd_pkg::RW-1:0];
        root_nxt[k] = {in_root[k][ssd_pkg::MW-2:0], 1'b0};
      end
    end
    rnd = {1'b0, root_r[ssd_pkg::SQ_STEPS-1]} + ((ssd_pkg::MW+1)'(1) << (ssd_pkg::RND_SH-1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ssd_pkg::SQ_STEPS; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= in_rad[k] << 2;
      end
      if (rnd[ssd_pkg::MW:ssd_pkg::RND_SH] >
          (ssd_pkg::MW+1-ssd_pkg::RND_SH)'(ssd_pkg::OUT_MAX)) begin
        dist_r <= ssd_pkg::OUT_MAX;
      end else begin
        dist_r <= rnd[ssd_pkg::RND_SH+ssd_pkg::DIST_W-1:ssd_pkg::RND_SH];
      end
    end
  end

  assign distance = dist_r;

endmodule

`default_nettype wire

// ===== src/ssd_chk.sv =====
// port level checks for the segment distance pipeline, bound to the top level
`default_nettype none

module ssd_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ssd_pkg::DIST_W-1:0]  out_distance
);

  // the pipeline only stalls when a finished item is held at the output
  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output occupancy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_distance))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind segment_segment_distance_3d ssd_chk u_ssd_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_seg.ready),
  .out_valid    (out_dist.valid),
  .out_ready    (out_dist.ready),
  .out_distance (out_dist.data.closest_distance)
);

`default_nettype wire
